### rtl/rhp_pkg.sv
// RTP header parser: shared types and constants.
// No dependencies; used by the front end, back end and top level of the parser.
package rhp_pkg;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_RTCP = 2'd1;
   localparam logic [1:0] STATUS_ERR  = 2'd2;

   localparam logic [1:0] VERSION_RTP  = 2'd2;
   localparam logic [1:0] VERSION_ZERO = 2'd0;

   localparam logic [6:0] RTCP_PT_LOW  = 7'd72;
   localparam logic [6:0] RTCP_PT_HIGH = 7'd76;

   localparam int FIXED_HEADER = 12;
   localparam int EXT_HEADER   = 4;
   localparam int LEN_W        = 16;
   localparam int OFFSET_W     = 19;
   localparam int SIZE_W       = 13;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [1:0]          hdr_version;
      logic                marker_bit;
      logic [6:0]          payload_type;
      logic [15:0]         sequence_number;
      logic [31:0]         rtp_timestamp;
      logic [31:0]         source_id;
      logic [OFFSET_W-1:0] payload_offset;
      logic [SIZE_W-1:0]   payload_size;
   } rsp_type;

   // Per-packet summary handed from the byte collector to the verdict logic.
   typedef struct packed {
      logic [7:0]       first_byte;
      logic [7:0]       second_byte;
      logic [15:0]      seq;
      logic [31:0]      ts;
      logic [31:0]      ssrc;
      logic [15:0]      ext_words;
      logic             ext_seen;
      logic [7:0]       prev_byte;
      logic [LEN_W-1:0] len;
      logic             len_err;
   } pkt_type;

endpackage

### rtl/rhp_queue.sv
// RTP header parser: small register queue with combinational head.
// Depends on nothing; carries packet summaries and results.
module rhp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output logic [WIDTH-1:0] head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

### rtl/rhp_front.sv
// RTP header parser front end: collects header bytes of one packet and,
// on the final byte, emits a packet summary. Depends on rhp_pkg.
module rhp_front #(
   parameter int MAX_PACKET_BYTES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  rhp_pkg::req_type byte_data,
   output logic             rec_push,
   output rhp_pkg::pkt_type rec_data
);

   localparam int CNT_W  = $clog2(MAX_PACKET_BYTES + 2);
   localparam int IDX_W  = (CNT_W > 7) ? CNT_W : 7;
   localparam int WIDE_W = (CNT_W > rhp_pkg::LEN_W) ? CNT_W : rhp_pkg::LEN_W;

   logic [CNT_W-1:0] count_ff, count_in, count_upd;
   logic             too_long_ff, too_long_in, too_long_upd;
   logic [7:0]       first_ff, first_in;
   logic [7:0]       second_ff, second_in;
   logic [15:0]      seq_ff, seq_in;
   logic [31:0]      ts_ff, ts_in;
   logic [31:0]      ssrc_ff, ssrc_in;
   logic [15:0]      ext_words_ff, ext_words_in;
   logic             ext_seen_ff, ext_seen_in;
   logic [7:0]       prev_ff, prev_in;
   logic [IDX_W-1:0] idx, ext_at;
   logic [WIDE_W-1:0] len_wide;
   logic [7:0]       b;

   assign b         = byte_data.data_byte;
   assign idx       = IDX_W'(count_ff);
   assign ext_at    = IDX_W'(rhp_pkg::FIXED_HEADER) + IDX_W'({first_ff[3:0], 2'b00});
   assign count_upd = (count_ff <= CNT_W'(MAX_PACKET_BYTES)) ? count_ff + 1'b1 : count_ff;
   assign too_long_upd = too_long_ff || (count_upd > CNT_W'(MAX_PACKET_BYTES));
   assign len_wide  = WIDE_W'(count_upd);

   always_comb begin
      count_in     = count_ff;
      too_long_in  = too_long_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      seq_in       = seq_ff;
      ts_in        = ts_ff;
      ssrc_in      = ssrc_ff;
      ext_words_in = ext_words_ff;
      ext_seen_in  = ext_seen_ff;
      prev_in      = prev_ff;
      rec_push     = 1'b0;
      if (byte_valid) begin
         priority if (idx == IDX_W'(0)) begin
            first_in = b;
         end else if (idx == IDX_W'(1)) begin
            second_in = b;
         end else if (idx < IDX_W'(4)) begin
            seq_in = {seq_ff[7:0], b};
         end else if (idx < IDX_W'(8)) begin
            ts_in = {ts_ff[23:0], b};
         end else if (idx < IDX_W'(rhp_pkg::FIXED_HEADER)) begin
            ssrc_in = {ssrc_ff[23:0], b};
         end else if (idx == ext_at + IDX_W'(2)) begin
            ext_words_in = {ext_words_ff[7:0], b};
         end else if (idx == ext_at + IDX_W'(3)) begin
            ext_words_in = {ext_words_ff[7:0], b};
            ext_seen_in  = 1'b1;
         end else begin
         end
         prev_in     = b;
         count_in    = count_upd;
         too_long_in = too_long_upd;
         if (byte_data.last_byte) begin
            rec_push    = 1'b1;
            count_in    = '0;
            too_long_in = 1'b0;
            ext_seen_in = 1'b0;
         end
      end
   end

   always_comb begin
      rec_data.first_byte  = first_in;
      rec_data.second_byte = second_in;
      rec_data.seq         = seq_in;
      rec_data.ts          = ts_in;
      rec_data.ssrc        = ssrc_in;
      rec_data.ext_words   = ext_words_in;
      rec_data.ext_seen    = ext_seen_ff || (byte_valid && idx == ext_at + IDX_W'(3)
                             && idx >= IDX_W'(rhp_pkg::FIXED_HEADER));
      rec_data.prev_byte   = b;
      rec_data.len         = len_wide[rhp_pkg::LEN_W-1:0];
      rec_data.len_err     = too_long_upd || (count_upd < CNT_W'(rhp_pkg::FIXED_HEADER));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         too_long_ff <= 1'b0;
         ext_seen_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         too_long_ff <= too_long_in;
         ext_seen_ff <= ext_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      second_ff    <= second_in;
      seq_ff       <= seq_in;
      ts_ff        <= ts_in;
      ssrc_ff      <= ssrc_in;
      ext_words_ff <= ext_words_in;
      prev_ff      <= prev_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PACKET_BYTES + 1))
      else $error("byte count beyond saturation");

   assert property (@(posedge clock) disable iff (reset)
      (byte_valid && byte_data.last_byte) |=> (count_ff == '0 && !too_long_ff))
      else $error("packet state not cleared after final byte");

endmodule

### rtl/rhp_back.sv
// RTP header parser back end: turns packet summaries into verdicts in two
// stages (header length, then size and padding). Depends on rhp_pkg.
module rhp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             allow_version_zero,
   input  logic             rec_empty,
   input  rhp_pkg::pkt_type rec_head,
   output logic             rec_pop,
   input  logic             res_full,
   output logic             res_push,
   output rhp_pkg::rsp_type res_data
);

   localparam int OW = rhp_pkg::OFFSET_W;

   rhp_pkg::pkt_type  sa_rec_ff;
   logic [OW-1:0]     sa_offset_ff, offset_in;
   logic [1:0]        sa_status_ff, status_in;
   logic              sa_valid_ff, sa_valid_in;
   logic              sa_load;
   logic [1:0]        ver;
   logic [6:0]        pt;
   logic              ver_ok, is_rtcp;
   logic              over, pad_bad;
   logic [15:0]       dsize, dsize_pad, prev_wide;

   assign ver     = rec_head.first_byte[7:6];
   assign pt      = rec_head.second_byte[6:0];
   assign ver_ok  = (ver == rhp_pkg::VERSION_RTP)
                    || (ver == rhp_pkg::VERSION_ZERO && allow_version_zero);
   assign is_rtcp = (pt >= rhp_pkg::RTCP_PT_LOW) && (pt <= rhp_pkg::RTCP_PT_HIGH);

   always_comb begin
      offset_in = OW'(rhp_pkg::FIXED_HEADER) + OW'({rec_head.first_byte[3:0], 2'b00});
      if (rec_head.first_byte[4] && rec_head.ext_seen) begin
         offset_in = offset_in + OW'(rhp_pkg::EXT_HEADER) + OW'({rec_head.ext_words, 2'b00});
      end
      priority if (rec_head.len_err || !ver_ok) begin
         status_in = rhp_pkg::STATUS_ERR;
      end else if (is_rtcp) begin
         status_in = rhp_pkg::STATUS_RTCP;
      end else begin
         status_in = rhp_pkg::STATUS_OK;
      end
   end

   assign res_push    = sa_valid_ff && !res_full;
   assign sa_load     = !sa_valid_ff || res_push;
   assign rec_pop     = !rec_empty && sa_load;
   assign sa_valid_in = rec_pop || (sa_valid_ff && !res_push);

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else begin
         sa_valid_ff <= sa_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_pop) begin
         sa_rec_ff    <= rec_head;
         sa_offset_ff <= offset_in;
         sa_status_ff <= status_in;
      end
   end

   assign over      = sa_offset_ff > OW'(sa_rec_ff.len);
   assign dsize     = sa_rec_ff.len - sa_offset_ff[15:0];
   assign prev_wide = 16'(sa_rec_ff.prev_byte);
   assign pad_bad   = sa_rec_ff.first_byte[5] && (prev_wide >= dsize);
   assign dsize_pad = sa_rec_ff.first_byte[5] ? dsize - prev_wide : dsize;

   always_comb begin
      res_data        = '0;
      res_data.status = rhp_pkg::STATUS_ERR;
      unique case (sa_status_ff)
         rhp_pkg::STATUS_RTCP: begin
            res_data.status       = rhp_pkg::STATUS_RTCP;
            res_data.hdr_version  = sa_rec_ff.first_byte[7:6];
            res_data.payload_type = sa_rec_ff.second_byte[6:0];
         end
         rhp_pkg::STATUS_OK: begin
            if (!over && !pad_bad) begin
               res_data.status          = rhp_pkg::STATUS_OK;
               res_data.hdr_version     = sa_rec_ff.first_byte[7:6];
               res_data.marker_bit      = sa_rec_ff.second_byte[7];
               res_data.payload_type    = sa_rec_ff.second_byte[6:0];
               res_data.sequence_number = sa_rec_ff.seq;
               res_data.rtp_timestamp   = sa_rec_ff.ts;
               res_data.source_id       = sa_rec_ff.ssrc;
               res_data.payload_offset  = sa_offset_ff;
               res_data.payload_size    = dsize_pad[rhp_pkg::SIZE_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset) res_push |-> !res_full)
      else $error("result transfer into full queue");

   assert property (@(posedge clock) disable iff (reset)
      (res_push && res_data.status == rhp_pkg::STATUS_ERR)
      |-> (res_data.payload_offset == '0 && res_data.payload_size == '0
           && res_data.hdr_version == '0))
      else $error("error verdict carries nonzero fields");

   assert property (@(posedge clock) disable iff (reset)
      (sa_valid_ff && !res_push) |=> (sa_valid_ff && $stable(sa_offset_ff)))
      else $error("stalled verdict stage lost its contents");

endmodule

### rtl/rtp_header_parser.sv
// RTP header parser top level: byte collector, summary queue, verdict stages
// and result queue. Depends on rhp_pkg, rhp_front, rhp_queue, rhp_back.
//
//   channel   direction  handshake          payload
//   request   in         push / full       req_data  (rhp_pkg::req_type)
//   response  out        empty / pop       rsp_data  (rhp_pkg::rsp_type)
//   csr       in         csr_write_en      csr_write_data (allow_version_zero)
//
// One byte is taken per cycle; full rises only when the summary queue holds
// two packets the verdict stages cannot drain.
// After its final byte transfer, a packet passes through the summary queue, then the
// length/offset stage, then the result queue, where its verdict appears.
// Reset is synchronous and clears the queues and packet state;
// allow_version_zero resets to 1.
module rtp_header_parser #(
   parameter int MAX_PACKET_BYTES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  rhp_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output rhp_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic             csr_write_data
);

   localparam int PKT_W = $bits(rhp_pkg::pkt_type);
   localparam int RSP_W = $bits(rhp_pkg::rsp_type);

   logic             allow_v0_ff, allow_v0_in;
   logic             byte_valid;
   logic             rec_push, rec_pop, rec_full, rec_empty;
   rhp_pkg::pkt_type rec_in, rec_head;
   logic [PKT_W-1:0] rec_in_bits, rec_head_bits;
   logic             res_push, res_full;
   rhp_pkg::rsp_type res_data;
   logic [RSP_W-1:0] res_bits, rsp_bits;

   assign allow_v0_in = csr_write_en ? csr_write_data : allow_v0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_v0_ff <= 1'b1;
      end else begin
         allow_v0_ff <= allow_v0_in;
      end
   end

   assign full       = rec_full;
   assign byte_valid = push && !rec_full;

   rhp_front #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .byte_valid(byte_valid),
      .byte_data (req_data),
      .rec_push  (rec_push),
      .rec_data  (rec_in)
   );

   assign rec_in_bits = rec_in;
   assign rec_head    = rhp_pkg::pkt_type'(rec_head_bits);

   rhp_queue #(
      .WIDTH(PKT_W),
      .DEPTH(2)
   ) u_rec_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_push),
      .push_data(rec_in_bits),
      .pop      (rec_pop),
      .full     (rec_full),
      .empty    (rec_empty),
      .head     (rec_head_bits)
   );

   rhp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .allow_version_zero(allow_v0_ff),
      .rec_empty         (rec_empty),
      .rec_head          (rec_head),
      .rec_pop           (rec_pop),
      .res_full          (res_full),
      .res_push          (res_push),
      .res_data          (res_data)
   );

   assign res_bits = res_data;
   assign rsp_data = rhp_pkg::rsp_type'(rsp_bits);

   rhp_queue #(
      .WIDTH(RSP_W),
      .DEPTH(2)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (res_push),
      .push_data(res_bits),
      .pop      (pop),
      .full     (res_full),
      .empty    (empty),
      .head     (rsp_bits)
   );

endmodule
